// ----- rtl/ilist_pkg.sv -----
// shared types, codes and constants of the indexed list block
package ilist_pkg;

   // default sizing of the list
   localparam int MAX_ENTRIES_DEF      = 4096;
   localparam int INITIAL_CAPACITY_DEF = 4;

   // field widths of the stream ports
   localparam int MODE_W     = 3;
   localparam int POS_W      = 12;
   localparam int VAL_W      = 32;
   localparam int STAT_W     = 2;
   localparam int CNT_OUT_W  = 13;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 64;

   // request operation codes
   typedef enum logic [MODE_W-1:0] {
      MODE_APPEND = 3'd0,
      MODE_INSERT = 3'd1,
      MODE_SET    = 3'd2,
      MODE_GET    = 3'd3,
      MODE_REMOVE = 3'd4
   } mode_type;

   // result status codes
   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   // controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_FETCH,
      S_SHIFT,
      S_DRAIN,
      S_PUT,
      S_RESULT
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load_req;
      logic set_status;
      logic rd_ptr;
      logic take_data;
      logic wr_val;
      logic shift_init;
      logic shift_step;
      logic cnt_inc;
      logic cnt_dec;
      logic load_rsp;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      mode_type op;
      logic     ok;
      logic     at_end;
      logic     has_tail;
      logic     shift_last;
      logic     rsp_free;
   } stat_type;

endpackage

// ----- rtl/ilist_ctrl.sv -----
// controller state machine of the indexed list block
module ilist_ctrl
   import ilist_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.set_status = 1'b1;
            if (!stat.ok) begin
               state_in = S_RESULT;
            end else begin
               case (stat.op)
                  MODE_APPEND: begin
                     cmd.wr_val  = 1'b1;
                     cmd.cnt_inc = 1'b1;
                     state_in    = S_RESULT;
                  end
                  MODE_INSERT: begin
                     if (stat.at_end) begin
                        cmd.wr_val  = 1'b1;
                        cmd.cnt_inc = 1'b1;
                        state_in    = S_RESULT;
                     end else begin
                        cmd.shift_init = 1'b1;
                        state_in       = S_SHIFT;
                     end
                  end
                  MODE_SET, MODE_GET, MODE_REMOVE: begin
                     state_in = S_FETCH;
                  end
                  default: begin
                     state_in = S_RESULT;
                  end
               endcase
            end
         end
         S_FETCH: begin
            cmd.take_data = 1'b1;
            case (stat.op)
               MODE_SET: begin
                  cmd.wr_val = 1'b1;
                  state_in   = S_RESULT;
               end
               MODE_REMOVE: begin
                  if (stat.has_tail) begin
                     cmd.shift_init = 1'b1;
                     state_in       = S_SHIFT;
                  end else begin
                     cmd.cnt_dec = 1'b1;
                     state_in    = S_RESULT;
                  end
               end
               default: begin
                  state_in = S_RESULT;
               end
            endcase
         end
         S_SHIFT: begin
            cmd.rd_ptr     = 1'b1;
            cmd.shift_step = 1'b1;
            if (stat.shift_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // last moved word is written this cycle
            if (stat.op == MODE_INSERT) begin
               state_in = S_PUT;
            end else begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_RESULT;
            end
         end
         S_PUT: begin
            cmd.wr_val  = 1'b1;
            cmd.cnt_inc = 1'b1;
            state_in    = S_RESULT;
         end
         S_RESULT: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/ilist_dpath.sv -----
// datapath of the indexed list block: entry memory, count, capacity, result register
module ilist_dpath
   import ilist_pkg::*;
#(
   parameter int MAX_ENTRIES      = MAX_ENTRIES_DEF,
   parameter int INITIAL_CAPACITY = INITIAL_CAPACITY_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output stat_type                stat,
   input  logic [MODE_W-1:0]       req_mode,
   input  logic [POS_W-1:0]        req_position,
   input  logic signed [VAL_W-1:0] req_value,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output status_type              rsp_status,
   output logic signed [VAL_W-1:0] rsp_data_out,
   output logic [CNT_OUT_W-1:0]    rsp_entry_count,
   output logic [CNT_OUT_W-1:0]    rsp_capacity
);

   localparam int AW        = $clog2(MAX_ENTRIES);
   localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W     = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int FIRST_CAP = (INITIAL_CAPACITY > MAX_ENTRIES) ? MAX_ENTRIES
                                                                : INITIAL_CAPACITY;

   // request registers
   logic [MODE_W-1:0]       mode_ff;
   logic [IDX_W-1:0]        pos_ff;
   logic signed [VAL_W-1:0] val_ff;

   // list state
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic [CNT_W-1:0]        cap_ff;
   logic [CNT_W-1:0]        cap_in;
   logic [CNT_W:0]          cap_dbl;

   // result under construction
   status_type              status_ff;
   status_type              status_in;
   logic [VAL_W-1:0]        data_ff;

   // shift pipeline
   logic [AW-1:0]           ptr_ff;
   logic                    wr_pend_ff;
   logic [AW-1:0]           wr_addr_ff;
   logic [AW-1:0]           rd_addr;
   logic [VAL_W-1:0]        rd_data_ff;
   logic [VAL_W-1:0]        mem [MAX_ENTRIES];

   // output register
   logic                    rsp_valid_ff;
   status_type              rsp_status_ff;
   logic [VAL_W-1:0]        rsp_data_ff;
   logic [CNT_OUT_W-1:0]    rsp_count_ff;
   logic [CNT_OUT_W-1:0]    rsp_cap_ff;

   logic [IDX_W-1:0]        count_wide;
   logic                    full;
   logic                    shift_up;

   assign count_wide = IDX_W'(count_ff);
   assign full       = (count_ff == CNT_W'(MAX_ENTRIES));
   assign shift_up   = (mode_ff == MODE_INSERT);

   // request capture; append targets the current end of the list
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff <= req_mode;
         val_ff  <= req_value;
         if (req_mode == MODE_APPEND) begin
            pos_ff <= count_wide;
         end else begin
            pos_ff <= IDX_W'(req_position);
         end
      end
   end

   // request checks
   always_comb begin
      status_in = ST_OK;
      case (mode_ff)
         MODE_APPEND: begin
            if (full) status_in = ST_FULL;
         end
         MODE_INSERT: begin
            if (pos_ff > count_wide) status_in = ST_RANGE;
            else if (full)           status_in = ST_FULL;
         end
         MODE_SET, MODE_GET: begin
            if (pos_ff >= count_wide) status_in = ST_RANGE;
         end
         MODE_REMOVE: begin
            if (count_ff == '0)           status_in = ST_EMPTY;
            else if (pos_ff >= count_wide) status_in = ST_RANGE;
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   // status toward the controller
   always_comb begin
      stat.op       = mode_type'(mode_ff);
      stat.ok       = (status_in == ST_OK);
      stat.at_end   = (pos_ff == count_wide);
      stat.has_tail = ((IDX_W+1)'(pos_ff) + 1'b1) < (IDX_W+1)'(count_ff);
      stat.rsp_free = !rsp_valid_ff || rsp_tready;
      if (shift_up) begin
         stat.shift_last = (ptr_ff == AW'(pos_ff));
      end else begin
         stat.shift_last = (ptr_ff == AW'(count_ff - 1'b1));
      end
   end

   // capacity grows to the initial size, then doubles up to the maximum
   assign cap_dbl = {cap_ff, 1'b0};
   always_comb begin
      cap_in = cap_ff;
      if (cap_ff == '0) begin
         cap_in = CNT_W'(FIRST_CAP);
      end else if (count_ff == cap_ff) begin
         if (cap_dbl > (CNT_W+1)'(MAX_ENTRIES)) cap_in = CNT_W'(MAX_ENTRIES);
         else                                  cap_in = CNT_W'(cap_dbl);
      end
   end

   // count and capacity registers
   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc)      count_in = count_ff + 1'b1;
      else if (cmd.cnt_dec) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cap_ff   <= '0;
      end else begin
         count_ff <= count_in;
         if (cmd.cnt_inc) cap_ff <= cap_in;
      end
   end

   // status and returned word
   always_ff @(posedge clock) begin
      if (cmd.set_status) begin
         status_ff <= status_in;
         data_ff   <= '0;
      end else if (cmd.take_data) begin
         data_ff <= rd_data_ff;
      end
   end

   // shift pointer and pending write of a moved word
   always_ff @(posedge clock) begin
      if (cmd.shift_init) begin
         if (shift_up) ptr_ff <= AW'(count_ff - 1'b1);
         else          ptr_ff <= AW'(pos_ff) + 1'b1;
      end else if (cmd.shift_step) begin
         if (shift_up) begin
            ptr_ff     <= ptr_ff - 1'b1;
            wr_addr_ff <= ptr_ff + 1'b1;
         end else begin
            ptr_ff     <= ptr_ff + 1'b1;
            wr_addr_ff <= ptr_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pend_ff <= 1'b0;
      end else begin
         wr_pend_ff <= cmd.shift_step;
      end
   end

   // entry memory: one read port, one write port
   assign rd_addr = cmd.rd_ptr ? ptr_ff : AW'(pos_ff);

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (wr_pend_ff) begin
         mem[wr_addr_ff] <= rd_data_ff;
      end else if (cmd.wr_val) begin
         mem[AW'(pos_ff)] <= val_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_data_ff   <= data_ff;
         rsp_count_ff  <= CNT_OUT_W'(count_ff);
         rsp_cap_ff    <= CNT_OUT_W'(cap_ff);
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_data_out    = rsp_data_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_capacity    = rsp_cap_ff;

   // capacity always covers the held entries
   a_cap_covers: assert property (@(posedge clock) disable iff (reset)
      cap_ff >= count_ff)
      else $error("capacity below entry count");

   // count never exceeds the list depth
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count above maximum");

   // a growing request adds exactly one entry
   a_count_inc: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_inc |=> count_ff == $past(count_ff) + 1'b1)
      else $error("entry count did not step by one");

   // a moved word and a new word never meet on the write port
   a_wr_clash: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> !cmd.wr_val)
      else $error("write port conflict");

endmodule

// ----- rtl/indexed_list_insert_remove_top.sv -----
// Indexed list of signed words with insert, remove, set, get and append.
// Inserts before the end and removes of any but the last entry move the following words
// by one place, one word per cycle through the entry memory; append, get, set, insert at
// the end, removal of the last entry and rejected requests move no words.
// One request is in flight: the next is taken once its result is registered.
// Reset (synchronous) clears count, capacity and control; entry memory is not cleared.
module indexed_list_insert_remove_top
   import ilist_pkg::*;
#(
   parameter int MAX_ENTRIES      = MAX_ENTRIES_DEF,
   parameter int INITIAL_CAPACITY = INITIAL_CAPACITY_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // position[11:0], value[43:12]
   input  logic [MODE_W-1:0]     req_tuser,   // mode[2:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // data_out[31:0], entry_count[44:32], capacity[57:45]
   output logic [STAT_W-1:0]     rsp_tuser    // status[1:0]
);

   cmd_type                 cmd;
   stat_type                stat;
   status_type              rsp_status;
   logic signed [VAL_W-1:0] rsp_data_out;
   logic [CNT_OUT_W-1:0]    rsp_entry_count;
   logic [CNT_OUT_W-1:0]    rsp_capacity;

   // controller
   ilist_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // datapath
   ilist_dpath #(
      .MAX_ENTRIES      (MAX_ENTRIES),
      .INITIAL_CAPACITY (INITIAL_CAPACITY)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_mode        (req_tuser),
      .req_position    (req_tdata[POS_W-1:0]),
      .req_value       (req_tdata[POS_W+VAL_W-1:POS_W]),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_status      (rsp_status),
      .rsp_data_out    (rsp_data_out),
      .rsp_entry_count (rsp_entry_count),
      .rsp_capacity    (rsp_capacity)
   );

   // result packing
   assign rsp_tdata = {{(RSP_DATA_W - VAL_W - 2*CNT_OUT_W){1'b0}},
                       rsp_capacity, rsp_entry_count, rsp_data_out};
   assign rsp_tuser = rsp_status;

endmodule
